[rtl/gzhs_pkg.sv]
`timescale 1ns / 1ps

package gzhs_pkg;

  // gzip member header constants
  localparam logic [7:0] MagicOne      = 8'h1f;
  localparam logic [7:0] MagicTwo      = 8'h8b;
  localparam logic [7:0] MethodDeflate = 8'h08;
  localparam logic [7:0] FlagReserved  = 8'hE0;
  localparam logic [4:0] FlagHcrc      = 5'h02;
  localparam logic [4:0] FlagExtra     = 5'h04;
  localparam logic [4:0] FlagName      = 5'h08;
  localparam logic [4:0] FlagComment   = 5'h10;

  localparam int unsigned FixedLen = 6;
  localparam int unsigned HcrcLen  = 2;

  // header section currently being parsed
  typedef enum logic [3:0] {
    PH_ID1   = 4'd0,
    PH_ID2   = 4'd1,
    PH_CM    = 4'd2,
    PH_FLG   = 4'd3,
    PH_FIXED = 4'd4,
    PH_XLO   = 4'd5,
    PH_XHI   = 4'd6,
    PH_XDATA = 4'd7,
    PH_NAME  = 4'd8,
    PH_COMM  = 4'd9,
    PH_HCRC  = 4'd10,
    PH_PAY   = 4'd11
  } phase_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_PAYLOAD     = 3'd0,
    ST_BAD_MAGIC   = 3'd1,
    ST_BAD_METHOD  = 3'd2,
    ST_TRUNCATED   = 3'd3,
    ST_HEADER_ONLY = 3'd4
  } status_e;

  // First enabled optional section at or after 'from', else the payload
  function automatic phase_e next_section(input phase_e from, input logic [4:0] flags);
    phase_e res;
    res = PH_PAY;
    if (from <= PH_HCRC && (flags & FlagHcrc) != '0) res = PH_HCRC;
    if (from <= PH_COMM && (flags & FlagComment) != '0) res = PH_COMM;
    if (from <= PH_NAME && (flags & FlagName) != '0) res = PH_NAME;
    if (from <= PH_XLO && (flags & FlagExtra) != '0) res = PH_XLO;
    return res;
  endfunction

endpackage

[rtl/gzip_header_stripper_unit.sv]
`timescale 1ns / 1ps

// Channel | Signals                                             | Direction
// input   | in_valid_i, in_ready_o, stream_byte_i, final_byte_i | sink
// output  | out_valid_o, out_ready_i, payload_byte_o, status_o,| source
//         | end_of_stream_o                                     |
//
// One byte per cycle, unless a result waits on a stalled output: a beat is held in the input register,
// then the phase logic decides its result and writes the output register.
// Reset clears the parser state and both valid flags; a final byte also
// restarts the parser. A stalled output only holds the input register when
// the waiting byte would itself produce a result.

module gzip_header_stripper_unit
  import gzhs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] stream_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic [2:0] status_o,
  output logic       end_of_stream_o
);

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_fin_q;

  // parser state
  phase_e      phase_q, phase_d;
  logic [4:0]  flags_q, flags_d;
  logic [15:0] count_q, count_d;
  logic        err_q, err_d;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  status_e    out_status_q;
  logic       out_eos_q;

  logic       has_res;
  logic [7:0] res_byte;
  status_e    res_status;
  logic       s1_go;
  logic       out_free;
  logic [15:0] count_inc;
  logic [15:0] count_dec;
  logic [15:0] xlen;

  assign count_inc = count_q + 16'd1;
  assign count_dec = count_q - 16'd1;
  assign xlen      = {s1_byte_q, count_q[7:0]};

  // Decode the held byte against the current phase
  always_comb begin
    phase_d    = phase_q;
    flags_d    = flags_q;
    count_d    = count_q;
    err_d      = err_q;
    has_res    = 1'b0;
    res_byte   = '0;
    res_status = ST_PAYLOAD;
    if (!err_q) begin
      unique case (phase_q)
        PH_ID1: begin
          if (s1_byte_q != MagicOne) begin
            res_status = ST_BAD_MAGIC;
            has_res    = 1'b1;
          end else begin
            phase_d = PH_ID2;
          end
        end
        PH_ID2: begin
          if (s1_byte_q != MagicTwo) begin
            res_status = ST_BAD_MAGIC;
            has_res    = 1'b1;
          end else begin
            phase_d = PH_CM;
          end
        end
        PH_CM: begin
          if (s1_byte_q != MethodDeflate) begin
            res_status = ST_BAD_METHOD;
            has_res    = 1'b1;
          end else begin
            phase_d = PH_FLG;
          end
        end
        PH_FLG: begin
          if ((s1_byte_q & FlagReserved) != '0) begin
            res_status = ST_BAD_METHOD;
            has_res    = 1'b1;
          end else begin
            flags_d = s1_byte_q[4:0];
            count_d = '0;
            phase_d = PH_FIXED;
          end
        end
        PH_FIXED: begin
          count_d = count_inc;
          if (count_inc >= 16'(FixedLen)) begin
            phase_d = next_section(PH_XLO, flags_q);
            count_d = '0;
          end
        end
        PH_XLO: begin
          count_d = {8'd0, s1_byte_q};
          phase_d = PH_XHI;
        end
        PH_XHI: begin
          count_d = xlen;
          if (xlen == '0) begin
            phase_d = next_section(PH_NAME, flags_q);
          end else begin
            phase_d = PH_XDATA;
          end
        end
        PH_XDATA: begin
          count_d = count_dec;
          if (count_dec == '0) begin
            phase_d = next_section(PH_NAME, flags_q);
            count_d = '0;
          end
        end
        PH_NAME: begin
          if (s1_byte_q == '0) begin
            phase_d = next_section(PH_COMM, flags_q);
            count_d = '0;
          end
        end
        PH_COMM: begin
          if (s1_byte_q == '0) begin
            phase_d = next_section(PH_HCRC, flags_q);
            count_d = '0;
          end
        end
        PH_HCRC: begin
          count_d = count_inc;
          if (count_inc >= 16'(HcrcLen)) begin
            phase_d = next_section(PH_PAY, flags_q);
            count_d = '0;
          end
        end
        default: begin
          // payload, and any unused phase code
          res_byte = s1_byte_q;
          has_res  = 1'b1;
        end
      endcase
      if (has_res && res_status != ST_PAYLOAD) begin
        err_d = 1'b1;
      end else if (!has_res && s1_fin_q) begin
        has_res    = 1'b1;
        res_status = (phase_d == PH_PAY) ? ST_HEADER_ONLY : ST_TRUNCATED;
      end
    end
    // restart after the last byte of a file
    if (s1_fin_q) begin
      phase_d = PH_ID1;
      flags_d = '0;
      count_d = '0;
      err_d   = 1'b0;
    end
  end

  // Advance the held byte unless its result has nowhere to go
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!has_res || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_comb begin
    if (s1_go && has_res) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_ID1;
      flags_q     <= '0;
      count_q     <= '0;
      err_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_go) begin
        phase_q <= phase_d;
        flags_q <= flags_d;
        count_q <= count_d;
        err_q   <= err_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= stream_byte_i;
      s1_fin_q  <= final_byte_i;
    end
    if (s1_go && has_res) begin
      out_byte_q   <= res_byte;
      out_status_q <= res_status;
      out_eos_q    <= s1_fin_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = out_byte_q;
  assign status_o        = out_status_q;
  assign end_of_stream_o = out_eos_q;

endmodule

[rtl/gzhs_checker.sv]
`timescale 1ns / 1ps

module gzhs_checker
  import gzhs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] stream_byte_i,
  input logic       final_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] payload_byte_o,
  input logic [2:0] status_o,
  input logic       end_of_stream_o
);

  // hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(status_o) && $stable(end_of_stream_o))
    else $error("stalled result beat changed");

  // no result beat right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat valid out of reset");

  // status codes stay within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_PAYLOAD || status_o == ST_BAD_MAGIC
      || status_o == ST_BAD_METHOD || status_o == ST_TRUNCATED
      || status_o == ST_HEADER_ONLY))
    else $error("undefined status code");

  // header-only and truncated results only mark the end of a file
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_TRUNCATED || status_o == ST_HEADER_ONLY)
      |-> end_of_stream_o)
    else $error("end status without end_of_stream");

  // non-payload results carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_PAYLOAD |-> payload_byte_o == 8'd0)
    else $error("nonzero byte on status result");

endmodule

bind gzip_header_stripper_unit gzhs_checker u_gzhs_checker (.*);

[bench/tb_gzip_header_stripper_unit.sv]
`timescale 1ns / 1ps

module tb_gzip_header_stripper_unit;
  import gzhs_pkg::*;

  localparam int HoldLen   = 200;
  localparam int TailWait  = 8;
  localparam int DrainMax  = 100000;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] payload;
    status_e    status;
    logic       eos;
  } hdr_result_t;

  // DUT signals
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] stream_byte = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] payload_byte;
  logic [2:0] status;
  logic       end_of_stream;

  // header parser shadow state
  phase_e      hp_phase = PH_ID1;
  logic [4:0]  hp_flags = '0;
  logic [15:0] hp_skip = '0;
  logic        hp_err = 1'b0;

  hdr_result_t pending_outputs[$];
  hdr_result_t head_beat;
  int          fail_cnt = 0;
  int          live_bytes = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_asked = 0;
  int          hold_taken = 0;
  int          hold_left = 0;

  gzip_header_stripper_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .stream_byte_i  (stream_byte),
    .final_byte_i   (final_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .payload_byte_o (payload_byte),
    .status_o       (status),
    .end_of_stream_o(end_of_stream)
  );

  always #10 clk_i = ~clk_i;

  // Return to the state after reset
  function automatic void parser_restart();
    hp_phase = PH_ID1;
    hp_flags = '0;
    hp_skip  = '0;
    hp_err   = 1'b0;
  endfunction

  // Jump to the first optional section enabled at or after 'from'
  function automatic void enter_section(input phase_e from);
    hp_skip = '0;
    if (from <= PH_XLO && (hp_flags & FlagExtra) != '0) hp_phase = PH_XLO;
    else if (from <= PH_NAME && (hp_flags & FlagName) != '0) hp_phase = PH_NAME;
    else if (from <= PH_COMM && (hp_flags & FlagComment) != '0) hp_phase = PH_COMM;
    else if (from <= PH_HCRC && (hp_flags & FlagHcrc) != '0) hp_phase = PH_HCRC;
    else hp_phase = PH_PAY;
  endfunction

  // Advance the shadow parser by one byte; return 1 when a result beat is due
  function automatic bit strip_byte(input logic [7:0] b, input logic fin,
                                    output hdr_result_t res);
    bit      got;
    bit      bad;
    status_e bad_code;
    got      = 1'b0;
    bad      = 1'b0;
    bad_code = ST_BAD_MAGIC;
    res      = '0;
    if (hp_err) begin
      if (fin) parser_restart();
      return 1'b0;
    end
    case (hp_phase)
      PH_ID1: begin
        if (b != MagicOne) begin bad = 1'b1; bad_code = ST_BAD_MAGIC; end
        else hp_phase = PH_ID2;
      end
      PH_ID2: begin
        if (b != MagicTwo) begin bad = 1'b1; bad_code = ST_BAD_MAGIC; end
        else hp_phase = PH_CM;
      end
      PH_CM: begin
        if (b != MethodDeflate) begin bad = 1'b1; bad_code = ST_BAD_METHOD; end
        else hp_phase = PH_FLG;
      end
      PH_FLG: begin
        if ((b & FlagReserved) != '0) begin
          bad = 1'b1;
          bad_code = ST_BAD_METHOD;
        end else begin
          hp_flags = b[4:0];
          hp_skip  = '0;
          hp_phase = PH_FIXED;
        end
      end
      PH_FIXED: begin
        hp_skip = hp_skip + 16'd1;
        if (hp_skip >= FixedLen) enter_section(PH_XLO);
      end
      PH_XLO: begin
        hp_skip  = {8'h00, b};
        hp_phase = PH_XHI;
      end
      PH_XHI: begin
        hp_skip = {b, hp_skip[7:0]};
        if (hp_skip == '0) enter_section(PH_NAME);
        else hp_phase = PH_XDATA;
      end
      PH_XDATA: begin
        hp_skip = hp_skip - 16'd1;
        if (hp_skip == '0) enter_section(PH_NAME);
      end
      PH_NAME: if (b == 8'h00) enter_section(PH_COMM);
      PH_COMM: if (b == 8'h00) enter_section(PH_HCRC);
      PH_HCRC: begin
        hp_skip = hp_skip + 16'd1;
        if (hp_skip >= HcrcLen) enter_section(PH_PAY);
      end
      default: begin
        res.payload = b;
        res.status  = ST_PAYLOAD;
        res.eos     = fin;
        got         = 1'b1;
      end
    endcase
    if (!got) begin
      if (bad) begin
        res.status = bad_code;
        res.eos    = fin;
        got        = 1'b1;
        hp_err     = 1'b1;
      end else if (fin) begin
        res.status = (hp_phase == PH_PAY) ? ST_HEADER_ONLY : ST_TRUNCATED;
        res.eos    = 1'b1;
        got        = 1'b1;
      end
    end
    if (fin) parser_restart();
    return got;
  endfunction

  // Offer one beat, wait for acceptance, then record what it must produce
  task automatic send_byte(input logic [7:0] b, input logic fin);
    hdr_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    final_byte  <= fin;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    live_bytes++;
    if (strip_byte(b, fin, res)) pending_outputs.push_back(res);
  endtask

  // Send a whole file, flagging its last byte
  task automatic send_member(input byte_q_t m);
    foreach (m[i]) send_byte(m[i], i == m.size() - 1);
  endtask

  // Hold off the sender until every result beat has come out
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_outputs.size() > 0 && waited < DrainMax) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TailWait) @(posedge clk_i);
  endtask

  // Build a random file: mostly well formed, some cut short, corrupted or noise
  task automatic send_random_member();
    byte_q_t    m;
    logic [4:0] flg;
    int         roll;
    int         xlen;
    roll = $urandom_range(0, 99);
    flg  = 5'($urandom);
    m    = {MagicOne, MagicTwo, MethodDeflate, {3'b000, flg}};
    repeat (FixedLen) m.push_back(8'($urandom));
    if ((flg & FlagExtra) != '0) begin
      xlen = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 4);
      m.push_back(xlen[7:0]);
      m.push_back(xlen[15:8]);
      repeat (xlen) m.push_back(8'($urandom));
    end
    if ((flg & FlagName) != '0) begin
      repeat ($urandom_range(0, 5)) m.push_back(8'($urandom_range(1, 255)));
      m.push_back(8'h00);
    end
    if ((flg & FlagComment) != '0) begin
      repeat ($urandom_range(0, 5)) m.push_back(8'($urandom_range(1, 255)));
      m.push_back(8'h00);
    end
    if ((flg & FlagHcrc) != '0) repeat (HcrcLen) m.push_back(8'($urandom));
    repeat ($urandom_range(0, 12)) m.push_back(8'($urandom));
    if (roll < 8) begin
      m = m[0:$urandom_range(0, m.size() - 1)];
    end else if (roll < 18) begin
      case ($urandom_range(0, 3))
        0: m[0] = m[0] ^ 8'($urandom_range(1, 255));
        1: m[1] = m[1] ^ 8'($urandom_range(1, 255));
        2: m[2] = m[2] ^ 8'($urandom_range(1, 255));
        default: m[3] = m[3] | {3'($urandom_range(1, 7)), 5'd0};
      endcase
    end else if (roll < 22) begin
      m = {};
      repeat ($urandom_range(1, 8)) m.push_back(8'($urandom));
    end
    send_member(m);
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected result beat: payload_byte %0h status %0d end_of_stream %0b",
               payload_byte, status, end_of_stream);
        fail_cnt++;
      end else begin
        head_beat = pending_outputs.pop_front();
        if (payload_byte !== head_beat.payload) begin
          $error("payload_byte: expected %0h, actual %0h", head_beat.payload, payload_byte);
          fail_cnt++;
        end
        if (status !== head_beat.status) begin
          $error("status: expected %0d, actual %0d", head_beat.status, status);
          fail_cnt++;
        end
        if (end_of_stream !== head_beat.eos) begin
          $error("end_of_stream: expected %0b, actual %0b", head_beat.eos, end_of_stream);
          fail_cnt++;
        end
      end
    end
  end

  // Drive ready: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_asked != hold_taken) begin
      hold_taken <= hold_asked;
      hold_left  <= HoldLen;
      out_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic test_bad_magic();
    byte_q_t m;
    // error on the final byte itself
    m = {8'h00};
    send_member(m);
    // wrong second magic, later bytes dropped up to the final one
    m = {MagicOne, 8'hFF, MagicTwo, 8'h55};
    send_member(m);
    drain();
  endtask

  task automatic test_bad_method_flags();
    byte_q_t m;
    m = {MagicOne, MagicTwo, 8'h07};
    send_member(m);
    m = {MagicOne, MagicTwo, MethodDeflate, 8'hE0, 8'h00};
    send_member(m);
    drain();
  endtask

  task automatic test_header_end();
    byte_q_t m;
    // final byte inside the fixed fields
    m = {MagicOne, MagicTwo, MethodDeflate, 8'h00, 8'h00, 8'h00};
    send_member(m);
    // header completes on the final byte, extra field of length zero
    m = {MagicOne, MagicTwo, MethodDeflate, FlagExtra | 5'h01,
         8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
    send_member(m);
    drain();
  endtask

  task automatic test_random(input int sidle, input int rstall, input int count);
    int stop_at;
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    stop_at = live_bytes + count;
    while (live_bytes < stop_at) send_random_member();
    drain();
  endtask

  // Stall the output long enough for the input to back up
  task automatic test_backpressure();
    byte_q_t m;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    m = {MagicOne, MagicTwo, MethodDeflate, 8'h00};
    repeat (FixedLen) m.push_back(8'($urandom));
    repeat (60) m.push_back(8'($urandom));
    @(negedge clk_i);
    hold_asked++;
    @(posedge clk_i);
    send_member(m);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bad_magic();
    test_bad_method_flags();
    test_header_end();
    test_random(0, 0, 250);
    test_random(45, 0, 250);
    test_random(0, 45, 250);
    test_random(22, 22, 250);
    test_backpressure();
    if (pending_outputs.size() != 0) begin
      $error("%0d result beats never arrived", pending_outputs.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
